FILE: rtl/core/boot_tape_image_loader_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the boot tape image loader
// Shared property forms, clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BOOT_TAPE_IMAGE_LOADER_UNIT_DEFINES_SVH
`define BOOT_TAPE_IMAGE_LOADER_UNIT_DEFINES_SVH

// same-cycle implication
`define BTIL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTIL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/btil_pkg.sv
// ----------------------------------------------------------------------------
// btil_pkg
// Types, constants and helpers shared by the tape image loader modules.
// ----------------------------------------------------------------------------
`default_nettype none

package btil_pkg;

  localparam int unsigned ByteW             = 8;
  localparam int unsigned WordW             = 16;
  localparam int unsigned AddrBitsDefault   = 16;
  localparam int unsigned QueueDepthDefault = 2;

  // header characters, after masking to 7 bits
  localparam logic [6:0] CharLf    = 7'h0A;
  localparam logic [6:0] CharCr    = 7'h0D;
  localparam logic [6:0] CharBang  = 7'h21;
  localparam logic [6:0] CharZero  = 7'h30;
  localparam logic [6:0] CharSeven = 7'h37;

  // front state
  typedef enum logic [1:0] {
    F_HEADER = 2'b01,
    F_WORDS  = 2'b10
  } front_state_e;

  // back state
  typedef enum logic [5:0] {
    ST_LOAD   = 6'b000001,
    ST_COUNT  = 6'b000010,
    ST_DATA   = 6'b000100,
    ST_CHECK  = 6'b001000,
    ST_ACTION = 6'b010000,
    ST_DONE   = 6'b100000
  } back_state_e;

  // octal values captured in the header
  typedef struct packed {
    logic [WordW-1:0] value_b;
    logic [WordW-1:0] value_c;
  } hdr_vals_t;

  // 1 when the byte has an even number of ones
  function automatic logic even_parity(input logic [ByteW-1:0] b);
    even_parity = ~(^b);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/btil_front.sv
// ----------------------------------------------------------------------------
// btil_front
// Takes tape bytes, parses the octal header and pairs later bytes into words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "boot_tape_image_loader_unit_defines.svh"

module btil_front import btil_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [ByteW-1:0] tape_byte_i,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output logic [WordW-1:0]      word_o,
  output hdr_vals_t             hdr_o
);

  front_state_e     state_q, state_d;
  logic             second_q, second_d;
  logic [ByteW-1:0] held_q;
  hdr_vals_t        hdr_q, hdr_d;
  logic             accept;
  logic [6:0]       ch;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign ch         = tape_byte_i[6:0];

  // header parse and word pairing
  always_comb begin
    state_d  = state_q;
    second_d = second_q;
    hdr_d    = hdr_q;
    push_o   = 1'b0;
    word_o   = {held_q, tape_byte_i};
    if (accept) begin
      unique case (state_q)
        F_HEADER: begin
          priority if (ch == CharLf) begin
            // line feed: no effect
          end else if (ch == CharCr) begin
            hdr_d.value_b = hdr_q.value_c;
            hdr_d.value_c = '0;
          end else if (ch >= CharZero && ch <= CharSeven) begin
            hdr_d.value_c = {hdr_q.value_c[WordW-4:0], ch[2:0]};
          end else if (ch == CharBang) begin
            state_d  = F_WORDS;
            second_d = 1'b0;
          end else begin
            hdr_d = '0;
          end
        end
        F_WORDS: begin
          second_d = ~second_q;
          push_o   = second_q;
        end
        default: state_d = F_HEADER;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_HEADER;
      second_q <= 1'b0;
      hdr_q    <= '0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
      hdr_q    <= hdr_d;
    end
  end

  // high byte of the word in progress
  always_ff @(posedge clk_i) begin
    if (accept && state_q == F_WORDS && !second_q) begin
      held_q <= tape_byte_i;
    end
  end

  assign hdr_o = hdr_q;

  `BTIL_ASSERT_NOW(a_no_push_in_header, state_q == F_HEADER, !push_o,
                   "front pushed a word during the header")
  `BTIL_ASSERT_NEXT(a_hdr_frozen, state_q == F_WORDS, $stable(hdr_q),
                    "header values changed after the header ended")

endmodule

`default_nettype wire

FILE: rtl/core/btil_queue.sv
// ----------------------------------------------------------------------------
// btil_queue
// Small word queue between the byte front and the result back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "boot_tape_image_loader_unit_defines.svh"

module btil_queue import btil_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WordW-1:0] word_i,
  input  wire logic             pop_i,
  output logic                  full_o,
  output logic                  valid_o,
  output logic [WordW-1:0]      word_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [WordW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign word_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

  `BTIL_ASSERT_NOW(a_no_push_full, full_o, !push_i, "word pushed into a full queue")
  `BTIL_ASSERT_NOW(a_count_range, 1'b1, count_q <= CntW'(Depth),
                   "queue fill count out of range")

endmodule

`default_nettype wire

FILE: rtl/core/btil_back.sv
// ----------------------------------------------------------------------------
// btil_back
// Walks the word sequence of the image and produces write and done results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "boot_tape_image_loader_unit_defines.svh"

module btil_back import btil_pkg::*; #(
  parameter int unsigned AddrBits = AddrBitsDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire logic [WordW-1:0] q_word_i,
  output logic                  pop_o,
  input  wire hdr_vals_t        hdr_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  kind_o,
  output logic [WordW-1:0]      address_o,
  output logic [ByteW-1:0]      low_byte_o,
  output logic [ByteW-1:0]      high_byte_o,
  output logic                  low_parity_o,
  output logic                  high_parity_o,
  output logic [WordW-1:0]      start_b_o,
  output logic [WordW-1:0]      start_c_o,
  output logic [WordW-1:0]      action_code_o,
  output logic                  checksum_ok_o,
  output logic [WordW-1:0]      computed_sum_o
);

  back_state_e       state_q, state_d;
  logic [WordW-1:0]  load_q, load_d;
  logic [WordW-1:0]  left_q, left_d;
  logic [AddrBits-1:0] addr_q, addr_d;
  logic [WordW-1:0]  sum_q, sum_d;
  logic [WordW-1:0]  chk_q, chk_d;
  logic              out_valid_q, out_valid_d;
  logic              emit_wr, emit_done;

  // a word is taken whenever the result slot is free or draining
  assign pop_o = q_valid_i & (~out_valid_q | ~out_stall_i);

  // word sequencer
  always_comb begin
    state_d   = state_q;
    load_d    = load_q;
    left_d    = left_q;
    addr_d    = addr_q;
    sum_d     = sum_q;
    chk_d     = chk_q;
    emit_wr   = 1'b0;
    emit_done = 1'b0;
    if (pop_o) begin
      unique case (state_q)
        ST_LOAD: begin
          load_d  = q_word_i;
          state_d = ST_COUNT;
        end
        ST_COUNT: begin
          left_d  = q_word_i;
          addr_d  = load_q[AddrBits-1:0];
          sum_d   = '0;
          state_d = (q_word_i == '0) ? ST_CHECK : ST_DATA;
        end
        ST_DATA: begin
          emit_wr = 1'b1;
          sum_d   = sum_q + q_word_i;
          addr_d  = addr_q + 1'b1;
          left_d  = left_q - 1'b1;
          if (left_q == WordW'(1)) begin
            state_d = ST_CHECK;
          end
        end
        ST_CHECK: begin
          chk_d   = q_word_i;
          state_d = ST_ACTION;
        end
        ST_ACTION: begin
          emit_done = 1'b1;
          state_d   = ST_DONE;
        end
        ST_DONE: begin
          // trailing bytes are dropped
        end
        default: state_d = ST_DONE;
      endcase
    end
  end

  // result slot handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_wr || emit_done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      load_q      <= '0;
      left_q      <= '0;
      addr_q      <= '0;
      sum_q       <= '0;
      chk_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_q      <= load_d;
      left_q      <= left_d;
      addr_q      <= addr_d;
      sum_q       <= sum_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, unused fields zero
  always_ff @(posedge clk_i) begin
    if (emit_wr) begin
      kind_o         <= 1'b0;
      address_o      <= WordW'(addr_q);
      low_byte_o     <= q_word_i[ByteW-1:0];
      high_byte_o    <= q_word_i[WordW-1:ByteW];
      low_parity_o   <= even_parity(q_word_i[ByteW-1:0]);
      high_parity_o  <= even_parity(q_word_i[WordW-1:ByteW]);
      start_b_o      <= '0;
      start_c_o      <= '0;
      action_code_o  <= '0;
      checksum_ok_o  <= 1'b0;
      computed_sum_o <= '0;
    end else if (emit_done) begin
      kind_o         <= 1'b1;
      address_o      <= '0;
      low_byte_o     <= '0;
      high_byte_o    <= '0;
      low_parity_o   <= 1'b0;
      high_parity_o  <= 1'b0;
      start_b_o      <= hdr_i.value_b;
      start_c_o      <= hdr_i.value_c;
      action_code_o  <= q_word_i;
      checksum_ok_o  <= (chk_q == sum_q);
      computed_sum_o <= sum_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `BTIL_ASSERT_NEXT(a_quiet_after_done, state_q == ST_DONE && !out_valid_q, !out_valid_q,
                    "result produced after load completion")
  `BTIL_ASSERT_NEXT(a_zero_count_skips,
                    pop_o && state_q == ST_COUNT && q_word_i == '0, state_q == ST_CHECK,
                    "zero word count did not skip the data words")

endmodule

`default_nettype wire

FILE: rtl/core/boot_tape_image_loader_unit.sv
// Boot tape image loader. Takes one tape byte per cycle (tape_byte_i beat
// accepted when in_valid_i is high and in_stall_o low) and sustains that rate
// as long as results are taken. The front parses the octal header and pairs
// the following bytes into 16-bit words; a two-entry word queue feeds the
// back, which walks load address, word count, data, checksum and action
// code. With the result register free, out_valid_o for a memory write rises
// from the low byte of its data word via the queue storage and out_valid_q,
// and the completion result likewise from the low byte of the action
// code. in_stall_o rises only when the word queue is full, which happens
// only while the result register is held by out_stall_i.
// After completion every further byte is taken and dropped until reset.
// ----------------------------------------------------------------------------
// boot_tape_image_loader_unit
// Top level: byte front, word queue and result back.
// ----------------------------------------------------------------------------
`default_nettype none

module boot_tape_image_loader_unit import btil_pkg::*; #(
  parameter int unsigned ADDR_BITS   = AddrBitsDefault,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [ByteW-1:0] tape_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  kind_o,
  output logic [WordW-1:0]      address_o,
  output logic [ByteW-1:0]      low_byte_o,
  output logic [ByteW-1:0]      high_byte_o,
  output logic                  low_parity_o,
  output logic                  high_parity_o,
  output logic [WordW-1:0]      start_b_o,
  output logic [WordW-1:0]      start_c_o,
  output logic [WordW-1:0]      action_code_o,
  output logic                  checksum_ok_o,
  output logic [WordW-1:0]      computed_sum_o
);

  logic             q_full, q_valid, push, pop;
  logic [WordW-1:0] push_word, q_word;
  hdr_vals_t        hdr;

  btil_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .tape_byte_i (tape_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .word_o      (push_word),
    .hdr_o       (hdr)
  );

  btil_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .word_i  (push_word),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .word_o  (q_word)
  );

  btil_back #(
    .AddrBits (ADDR_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_word_i       (q_word),
    .pop_o          (pop),
    .hdr_i          (hdr),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .address_o      (address_o),
    .low_byte_o     (low_byte_o),
    .high_byte_o    (high_byte_o),
    .low_parity_o   (low_parity_o),
    .high_parity_o  (high_parity_o),
    .start_b_o      (start_b_o),
    .start_c_o      (start_c_o),
    .action_code_o  (action_code_o),
    .checksum_ok_o  (checksum_ok_o),
    .computed_sum_o (computed_sum_o)
  );

endmodule

`default_nettype wire

FILE: test/boot_tape_image_loader_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boot_tape_image_loader_unit_tb
// Feeds one bootable tape image byte by byte: an octal header with every
// control character and noise, then the address, count, data, checksum and
// action words, then bytes that must be dropped. A predictor tracks the
// parse and checks every memory write and the final report beat by beat.
// ----------------------------------------------------------------------------

module boot_tape_image_loader_unit_tb;
  import btil_pkg::*;

  localparam int unsigned ADDR_BITS    = AddrBitsDefault;
  localparam logic [WordW-1:0] ADDR_MASK = WordW'((32'd1 << ADDR_BITS) - 32'd1);
  localparam int unsigned IDLE_MAX     = 11;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned DIRECT_WORDS = 4;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // parse position of the tape
  typedef enum logic [2:0] {
    TP_HEADER,
    TP_LOAD_ADDR,
    TP_WORD_COUNT,
    TP_DATA,
    TP_CHECKSUM,
    TP_ACTION,
    TP_DONE
  } tape_phase_e;

  typedef struct packed {
    logic             kind;
    logic [WordW-1:0] address;
    logic [ByteW-1:0] low_byte;
    logic [ByteW-1:0] high_byte;
    logic             low_parity;
    logic             high_parity;
    logic [WordW-1:0] start_b;
    logic [WordW-1:0] start_c;
    logic [WordW-1:0] action_code;
    logic             checksum_ok;
    logic [WordW-1:0] computed_sum;
  } loader_result_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [ByteW-1:0] tape_byte_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             kind_o;
  logic [WordW-1:0] address_o;
  logic [ByteW-1:0] low_byte_o;
  logic [ByteW-1:0] high_byte_o;
  logic             low_parity_o;
  logic             high_parity_o;
  logic [WordW-1:0] start_b_o;
  logic [WordW-1:0] start_c_o;
  logic [WordW-1:0] action_code_o;
  logic             checksum_ok_o;
  logic [WordW-1:0] computed_sum_o;

  // predictor state
  tape_phase_e      tp_phase   = TP_HEADER;
  logic             low_due    = 1'b0;
  logic [ByteW-1:0] held_msb   = '0;
  logic [WordW-1:0] hdr_b      = '0;
  logic [WordW-1:0] hdr_c      = '0;
  logic [WordW-1:0] base_addr  = '0;
  logic [WordW-1:0] words_left = '0;
  logic [WordW-1:0] word_idx   = '0;
  logic [WordW-1:0] sum_acc    = '0;
  logic [WordW-1:0] sum_ref    = '0;

  loader_result_t due_results[$];

  bit          calm         = 1'b0;
  int unsigned data_count   = 0;
  int unsigned bytes_sent   = 0;
  int unsigned writes_seen  = 0;
  int unsigned reports_seen = 0;
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;

  boot_tape_image_loader_unit #(
    .ADDR_BITS(ADDR_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .tape_byte_i   (tape_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .address_o     (address_o),
    .low_byte_o    (low_byte_o),
    .high_byte_o   (high_byte_o),
    .low_parity_o  (low_parity_o),
    .high_parity_o (high_parity_o),
    .start_b_o     (start_b_o),
    .start_c_o     (start_c_o),
    .action_code_o (action_code_o),
    .checksum_ok_o (checksum_ok_o),
    .computed_sum_o(computed_sum_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // switch between idling and back-to-back stretches
  always begin
    repeat ($urandom_range(30, 150)) @(posedge clk_i);
    calm <= ($urandom_range(0, 2) == 0);
  end

  // advance the tape parse by one accepted byte, queue any result it causes
  task automatic parse_tape_byte(input logic [ByteW-1:0] b);
    logic [6:0]       c;
    logic [WordW-1:0] word;
    logic [WordW-1:0] addr_sum;
    loader_result_t   r;
    c = b[6:0];
    r = '0;
    case (tp_phase)
      TP_HEADER: begin
        // line feed is skipped entirely
        if (c != CharLf) begin
          if (c == CharCr) begin
            hdr_b = hdr_c;
            hdr_c = '0;
          end else if (c >= CharZero && c <= CharSeven) begin
            hdr_c = {hdr_c[WordW-4:0], c[2:0]};
          end else if (c == CharBang) begin
            tp_phase = TP_LOAD_ADDR;
            low_due  = 1'b0;
          end else begin
            hdr_b = '0;
            hdr_c = '0;
          end
        end
      end
      TP_DONE: begin
        // dropped until reset
      end
      default: begin
        if (!low_due) begin
          held_msb = b;
          low_due  = 1'b1;
        end else begin
          low_due = 1'b0;
          word    = {held_msb, b};
          case (tp_phase)
            TP_LOAD_ADDR: begin
              base_addr = word;
              tp_phase  = TP_WORD_COUNT;
            end
            TP_WORD_COUNT: begin
              words_left = word;
              word_idx   = '0;
              sum_acc    = '0;
              tp_phase   = (word == '0) ? TP_CHECKSUM : TP_DATA;
            end
            TP_DATA: begin
              addr_sum      = base_addr + word_idx;
              r.kind        = KIND_WRITE;
              r.address     = addr_sum & ADDR_MASK;
              r.low_byte    = word[7:0];
              r.high_byte   = word[15:8];
              r.low_parity  = ~^word[7:0];
              r.high_parity = ~^word[15:8];
              due_results.push_back(r);
              sum_acc    = sum_acc + word;
              word_idx   = word_idx + 1'b1;
              words_left = words_left - 1'b1;
              if (words_left == '0) tp_phase = TP_CHECKSUM;
            end
            TP_CHECKSUM: begin
              sum_ref  = word;
              tp_phase = TP_ACTION;
            end
            default: begin
              r.kind         = KIND_REPORT;
              r.start_b      = hdr_b;
              r.start_c      = hdr_c;
              r.action_code  = word;
              r.checksum_ok  = (sum_ref == sum_acc);
              r.computed_sum = sum_acc;
              due_results.push_back(r);
              tp_phase = TP_DONE;
            end
          endcase
        end
      end
    endcase
  endtask

  // one input beat, after a random gap
  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    tape_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    parse_tape_byte(b);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [WordW-1:0] w);
    send_byte(w[15:8]);
    send_byte(w[7:0]);
  endtask

  // 7-bit character with a random top bit
  function automatic logic [ByteW-1:0] with_top(input logic [6:0] c);
    return {1'($urandom_range(0, 1)), c};
  endfunction

  task automatic test_header_directed();
    logic [ByteW-1:0] seq[$];
    // six sevens overflow the accumulator; LF plain and with bit 7; digits
    // with bit 7; a letter clears; CR with bit 7; '8' is not octal and
    // clears; 0x00, 0xFF and DEL are noise
    seq = {8'h37, 8'h37, 8'h37, 8'h37, 8'h37, 8'h37, 8'h0D, 8'h0A, 8'h8A,
           8'hB0, 8'hB7, 8'h78, 8'h31, 8'h32, 8'h33, 8'h8D, 8'h34, 8'h35,
           8'h38, 8'h36, 8'h00, 8'hFF, 8'h7F, 8'h37, 8'h0D};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_header_random();
    int unsigned      n;
    int unsigned      sel;
    logic [ByteW-1:0] b;
    n = $urandom_range(30, 50);
    repeat (n) begin
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        b = with_top(CharZero + 7'($urandom_range(0, 7)));
      end else if (sel == 5) begin
        b = with_top(CharCr);
      end else if (sel == 6) begin
        b = with_top(CharLf);
      end else begin
        do b = ByteW'($urandom_range(0, 255)); while (b[6:0] == CharBang);
      end
      send_byte(b);
    end
    // leave both octal values populated before the delimiter
    repeat ($urandom_range(1, 6)) send_byte(with_top(CharZero + 7'($urandom_range(0, 7))));
    send_byte(with_top(CharCr));
    repeat ($urandom_range(1, 6)) send_byte(with_top(CharZero + 7'($urandom_range(0, 7))));
    // plain '!' or '!' with bit 7 set both end the header
    send_byte(with_top(CharBang));
  endtask

  task automatic test_load_setup();
    logic [WordW-1:0] addr;
    // a base near the top makes the write address wrap
    if ($urandom_range(0, 3) == 0) addr = 16'hFFFF - WordW'($urandom_range(0, 40));
    else addr = WordW'($urandom_range(0, 65535));
    // a zero count skips straight to the checksum
    data_count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(100, 170);
    send_word(addr);
    send_word(WordW'(data_count));
  endtask

  task automatic test_data_words();
    logic [WordW-1:0] edge_words[DIRECT_WORDS];
    logic [WordW-1:0] w;
    edge_words = '{16'h0000, 16'hFFFF, 16'h8001, 16'h7EFE};
    for (int unsigned i = 0; i < data_count; i++) begin
      w = (i < DIRECT_WORDS) ? edge_words[i] : WordW'($urandom_range(0, 65535));
      send_word(w);
    end
  endtask

  task automatic test_trailer();
    logic [WordW-1:0] check;
    logic [WordW-1:0] action;
    check  = $urandom_range(0, 1) ? sum_acc : WordW'($urandom_range(0, 65535));
    action = ($urandom_range(0, 2) == 0) ? '0 : WordW'($urandom_range(1, 65535));
    send_word(check);
    send_word(action);
  endtask

  // anything after the report is dropped
  task automatic test_after_done();
    repeat (20) send_byte(ByteW'($urandom_range(0, 255)));
  endtask

  // result side: random hold-off per beat
  initial begin : drive_out_stall
    int unsigned hold;
    wait (rst_ni === 1'b1);
    forever begin
      hold = calm ? 0 : $urandom_range(0, IDLE_MAX);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  function automatic int unsigned field_diff(input string name,
                                             input logic [WordW-1:0] want,
                                             input logic [WordW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : check_beat
    loader_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (due_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, kind %b address %h",
                 $time, kind_o, address_o);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        fail_count += field_diff("kind", WordW'(want.kind), WordW'(kind_o));
        fail_count += field_diff("address", want.address, address_o);
        fail_count += field_diff("low_byte", WordW'(want.low_byte), WordW'(low_byte_o));
        fail_count += field_diff("high_byte", WordW'(want.high_byte), WordW'(high_byte_o));
        fail_count += field_diff("low_parity", WordW'(want.low_parity),
                                 WordW'(low_parity_o));
        fail_count += field_diff("high_parity", WordW'(want.high_parity),
                                 WordW'(high_parity_o));
        fail_count += field_diff("start_b", want.start_b, start_b_o);
        fail_count += field_diff("start_c", want.start_c, start_c_o);
        fail_count += field_diff("action_code", want.action_code, action_code_o);
        fail_count += field_diff("checksum_ok", WordW'(want.checksum_ok),
                                 WordW'(checksum_ok_o));
        fail_count += field_diff("computed_sum", want.computed_sum, computed_sum_o);
        if (want.kind == KIND_WRITE) writes_seen++;
        else reports_seen++;
      end
    end
  end

  // stop a hung run: too long with no beat on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, due_results.size());
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_header_directed();
    test_header_random();
    test_load_setup();
    test_data_words();
    test_trailer();
    test_after_done();

    // last byte was taken at this edge; stop offering it again
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (due_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, due_results.size());
      fail_count += due_results.size();
    end

    $display("Sent %0d tape bytes; checked %0d memory writes and %0d load reports",
             bytes_sent, writes_seen, reports_seen);
    $display("Image of %0d data words at base %h, checksum %s",
             data_count, base_addr, (sum_ref == sum_acc) ? "matching" : "corrupted");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
